### rtl/dq_pkg.sv
// Shared constants, codes and control types of the double-ended queue.
package dq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_W     = 32;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CMD_W      = 3;
    localparam int POS_W      = 4;
    localparam int STATUS_W   = 2;
    localparam int OUT_CNT_W  = 5;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;

    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_INDEX = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PEEK_BACK  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic load;
        logic exec;
        logic finish;
    } t_dq_cmd;

    typedef struct packed {
        logic out_free;
    } t_dq_stat;

endpackage

### rtl/dq_ram.sv
// Generic single-port RAM with registered read data.
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/dq_ctrl.sv
// Controller state machine that sequences one command through the datapath.
module dq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  dq_pkg::t_dq_stat  i_stat,
    output logic              o_s_tready,
    output dq_pkg::t_dq_cmd   o_cmd
);
    import dq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_s_tready  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.exec)
        else $error("execute step did not follow a load");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> !o_s_tready)
        else $error("new word accepted before the result was stored");

endmodule

### rtl/dq_dp.sv
// Datapath: ring store, front pointer, entry count and output register.
module dq_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  dq_pkg::t_dq_cmd                 i_cmd,
    output dq_pkg::t_dq_stat                o_stat,
    input  logic [dq_pkg::CMD_W-1:0]        i_op,
    input  logic [dq_pkg::DATA_W-1:0]       i_value,
    input  logic [dq_pkg::POS_W-1:0]        i_pos,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [dq_pkg::DATA_W-1:0]       o_data_out,
    output logic [dq_pkg::STATUS_W-1:0]     o_status,
    output logic [dq_pkg::OUT_CNT_W-1:0]    o_count
);
    import dq_pkg::*;

    logic [CMD_W-1:0]     r_op;
    logic [DATA_W-1:0]    r_value;
    logic [POS_W-1:0]     r_pos;
    logic [PTR_W-1:0]     r_front;
    logic [PTR_W-1:0]     n_front;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [STATUS_W-1:0]  r_status;
    logic [STATUS_W-1:0]  n_status;
    logic                 r_rd;
    logic                 r_out_valid;
    logic [DATA_W-1:0]    r_out_data;
    logic [STATUS_W-1:0]  r_out_status;
    logic [CNT_W-1:0]     r_out_count;

    logic                 full;
    logic                 empty;
    logic                 pos_bad;
    logic [PTR_W-1:0]     offset;
    logic [PTR_W:0]       sum;
    logic [PTR_W-1:0]     slot;
    logic [PTR_W-1:0]     front_dec;
    logic [PTR_W-1:0]     front_inc;
    logic                 we;
    logic                 re;
    logic [PTR_W-1:0]     addr;
    logic [DATA_W-1:0]    rdata;

    assign full    = (r_count == CNT_W'(DEPTH));
    assign empty   = (r_count == '0);
    assign pos_bad = ({{CNT_W{1'b0}}, r_pos} >= {{POS_W{1'b0}}, r_count});

    always_comb begin
        case (r_op)
            CMD_PUSH_BACK: offset = r_count[PTR_W-1:0];
            CMD_READ_INDEX: offset = PTR_W'(r_pos);
            default: offset = PTR_W'(r_count - CNT_W'(1));
        endcase
    end

    assign sum  = {1'b0, r_front} + {1'b0, offset};
    assign slot = (sum >= (PTR_W+1)'(DEPTH)) ? PTR_W'(sum - (PTR_W+1)'(DEPTH))
                                             : sum[PTR_W-1:0];
    assign front_dec = (r_front == '0) ? PTR_W'(DEPTH - 1) : r_front - PTR_W'(1);
    assign front_inc = (r_front == PTR_W'(DEPTH - 1)) ? '0 : r_front + PTR_W'(1);

    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_status = ST_OK;
        we       = 1'b0;
        re       = 1'b0;
        addr     = slot;
        case (r_op)
            CMD_PUSH_BACK: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    we      = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_PUSH_FRONT: begin
                addr = front_dec;
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    we      = 1'b1;
                    n_front = front_dec;
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_POP_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    re      = 1'b1;
                    n_count = r_count - CNT_W'(1);
                end
            end
            CMD_POP_FRONT: begin
                addr = r_front;
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    re      = 1'b1;
                    n_front = front_inc;
                    n_count = r_count - CNT_W'(1);
                end
            end
            CMD_READ_INDEX: begin
                if (pos_bad) begin
                    n_status = ST_EMPTY;
                end else begin
                    re = 1'b1;
                end
            end
            CMD_PEEK_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    re = 1'b1;
                end
            end
            CMD_PEEK_FRONT: begin
                addr = r_front;
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    re = 1'b1;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    dq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec & we),
        .i_re    (i_cmd.exec & re),
        .i_addr  (addr),
        .i_wdata (r_value),
        .o_rdata (rdata)
    );

    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_value <= i_value;
            r_pos   <= i_pos;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_rd     <= re;
        end
        if (i_cmd.finish) begin
            r_out_data   <= r_rd ? rdata : '0;
            r_out_status <= r_status;
            r_out_count  <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_front <= n_front;
                r_count <= n_count;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_out_data;
    assign o_status    = r_out_status;
    assign o_count     = OUT_CNT_W'(r_out_count);

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above the ring depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result word overwritten before it was taken");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> ($stable(r_front) && $stable(r_count)))
        else $error("pointer or count moved outside the execute step");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_FULL) |-> (r_out_count == CNT_W'(DEPTH)))
        else $error("full status reported with room left");

endmodule

### rtl/double_ended_queue.sv
// Top level of the double-ended queue: controller and datapath.
//
//  channel  | dir | tdata fields (low bit up)                 | tuser
//  ---------+-----+-------------------------------------------+-------------
//  s        | in  | value[31:0], position[35:32], zero fill   | cmd[2:0]
//  m        | out | data_out[31:0], status[33:32], count[38:34], zero fill | none
//
//  Each command word passes through three steps: load, one ring access, and the
//  transfer into the output register, which waits while a result is untaken.
//  The result word is valid once stored there; new commands are accepted in idle.
//  The ring store is a RAM with registered read, which sets the middle step.
//  A result word waiting in the output register does not block the next
//  command; only a second finished result waits for the first to be taken.
//  Reset is synchronous and active low; it empties the queue at once.
module double_ended_queue (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [dq_pkg::S_TDATA_W-1:0]     i_s_tdata,  // value, position
    input  logic [dq_pkg::CMD_W-1:0]         i_s_tuser,  // cmd
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [dq_pkg::M_TDATA_W-1:0]     o_m_tdata   // data_out, status, count
);
    import dq_pkg::*;

    t_dq_cmd                cmd;
    t_dq_stat               stat;
    logic [DATA_W-1:0]      data_out;
    logic [STATUS_W-1:0]    status;
    logic [OUT_CNT_W-1:0]   count;

    dq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_stat     (stat),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    dq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_op        (i_s_tuser),
        .i_value     (i_s_tdata[DATA_W-1:0]),
        .i_pos       (i_s_tdata[DATA_W+POS_W-1:DATA_W]),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_data_out  (data_out),
        .o_status    (status),
        .o_count     (count)
    );

    assign o_m_tdata = {{(M_TDATA_W - DATA_W - STATUS_W - OUT_CNT_W){1'b0}},
                        count, status, data_out};

endmodule
